[rtl/core/blce_pkg.sv]
// ----------------------------------------------------------------------------
// blce_pkg
// Shared constants, codes and control types of the bounded list engine.
// ----------------------------------------------------------------------------
package blce_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VAL_W     = 32;
	localparam int OP_W      = 4;
	localparam int ST_W      = 2;
	localparam int SQ_W      = 37;
	localparam int DIV_W     = 17;

	localparam logic [OP_W-1:0] OP_INS_HEAD = 4'd0;
	localparam logic [OP_W-1:0] OP_INS_TAIL = 4'd1;
	localparam logic [OP_W-1:0] OP_INS_PAIR = 4'd2;
	localparam logic [OP_W-1:0] OP_SEARCH   = 4'd3;
	localparam logic [OP_W-1:0] OP_DEL_HEAD = 4'd4;
	localparam logic [OP_W-1:0] OP_DEL_TAIL = 4'd5;
	localparam logic [OP_W-1:0] OP_DEL_GT   = 4'd6;
	localparam logic [OP_W-1:0] OP_DEL_EVEN = 4'd7;
	localparam logic [OP_W-1:0] OP_SORT     = 4'd8;
	localparam logic [OP_W-1:0] OP_PRIMES   = 4'd9;
	localparam logic [OP_W-1:0] OP_SQUARES  = 4'd10;
	localparam logic [OP_W-1:0] OP_MINMAX   = 4'd11;
	localparam logic [OP_W-1:0] OP_READOUT  = 4'd12;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS2,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_PR_W3,
		S_PR_SQ,
		S_PR_SQC,
		S_PR_WA,
		S_PR_WB,
		S_SQ_W,
		S_SORT_END,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MS_MOD3,
		MS_MODD,
		MS_MODD2,
		MS_SQRT
	} math_sel_t;

	typedef struct packed {
		logic            load;
		logic            set_status;
		logic [ST_W-1:0] status_val;
		logic            ins_head;
		logic            ins_tail;
		logic            ins_second;
		logic            del_head;
		logic            del_tail;
		logic            rd;
		logic            step;
		logic            keep_wr;
		logic            set_cnt_w;
		logic            sort_first;
		logic            sort_cmp;
		logic            sort_end;
		logic            mm_first;
		logic            mm_upd;
		logic            found;
		logic            prime_inc;
		logic            sq_add;
		logic            d_init;
		logic            d_step;
		logic            sq_load;
		logic            math_start;
		math_sel_t       math_sel;
		logic            set_elem;
		logic            emit;
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            pair_full;
		logic            empty;
		logic            scan_end;
		logic            k_zero;
		logic            eq;
		logic            gt;
		logic            t_lt2;
		logic            t_lt4;
		logic            t_even;
		logic            t_neg;
		logic            math_done;
		logic            math_zero;
		logic            prod_gt;
		logic            swapped;
		logic            e_le1;
		logic            last;
		logic            out_free;
	} dp_stat_t;

endpackage

[rtl/core/blce_math.sv]
// ----------------------------------------------------------------------------
// blce_math
// Iterative remainder and integer square root unit, one bit or one root
// digit per cycle.
// ----------------------------------------------------------------------------
module blce_math (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       is_sqrt,
	input  logic [30:0]                operand,
	input  logic [blce_pkg::DIV_W-1:0] divisor,
	output logic                       done,
	output logic                       zero
);
	import blce_pkg::*;

	localparam logic [4:0] MOD_LAST  = 5'd30;
	localparam logic [4:0] SQRT_LAST = 5'd15;

	logic             busy_q;
	logic             done_q;
	logic             sqrt_q;
	logic [4:0]       cnt_q;
	logic [31:0]      num_q;
	logic [DIV_W:0]   rem_q;
	logic [DIV_W-1:0] div_q;
	logic [31:0]      res_q;
	logic [31:0]      bit_q;
	logic [DIV_W:0]   rem_sh;
	logic [31:0]      trial;

	assign rem_sh = {rem_q[DIV_W-1:0], num_q[30]};
	assign trial  = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 5'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sqrt_q <= is_sqrt;
			num_q  <= {1'b0, operand};
			rem_q  <= '0;
			div_q  <= divisor;
			res_q  <= '0;
			bit_q  <= 32'h4000_0000;
			cnt_q  <= is_sqrt ? SQRT_LAST : MOD_LAST;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (sqrt_q) begin
				if (num_q >= trial) begin
					num_q <= num_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				num_q <= num_q << 1;
				if (rem_sh >= {1'b0, div_q}) begin
					rem_q <= rem_sh - {1'b0, div_q};
				end else begin
					rem_q <= rem_sh;
				end
			end
		end
	end

	assign done = done_q;
	assign zero = sqrt_q ? (num_q == 32'd0) : (rem_q == '0);

endmodule

[rtl/core/blce_dp.sv]
// ----------------------------------------------------------------------------
// blce_dp
// Datapath: entry memory kept as a ring, list pointers, scan registers,
// result registers and the output register.
// ----------------------------------------------------------------------------
module blce_dp #(
	parameter int DEPTH = blce_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [blce_pkg::OP_W-1:0]         opcode,
	input  logic signed [blce_pkg::VAL_W-1:0] value,
	input  logic signed [blce_pkg::VAL_W-1:0] second_value,
	input  blce_pkg::dp_cmd_t                 cmd,
	output blce_pkg::dp_stat_t                stat,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [blce_pkg::ST_W-1:0]         status,
	output logic [$clog2(DEPTH+1)-1:0]        entry_count,
	output logic [$clog2(DEPTH+1)-1:0]        position,
	output logic signed [blce_pkg::VAL_W-1:0] element,
	output logic signed [blce_pkg::VAL_W-1:0] largest,
	output logic [$clog2(DEPTH+1)-1:0]        prime_count,
	output logic [blce_pkg::SQ_W-1:0]         square_sum,
	output logic                              last
);
	import blce_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic signed [VAL_W-1:0] mem [DEPTH];

	logic [IW-1:0]           front_q;
	logic [CW-1:0]           cnt_q;
	logic                    out_valid_q;
	logic [OP_W-1:0]         op_q;
	logic signed [VAL_W-1:0] v_q;
	logic signed [VAL_W-1:0] v2_q;
	logic [CW-1:0]           k_q;
	logic [CW-1:0]           w_q;
	logic [CW-1:0]           e_q;
	logic signed [VAL_W-1:0] rd_q;
	logic signed [VAL_W-1:0] cur_q;
	logic signed [VAL_W-1:0] elem_q;
	logic signed [VAL_W-1:0] hi_q;
	logic [CW-1:0]           pos_q;
	logic [CW-1:0]           primes_q;
	logic [SQ_W-1:0]         sq_q;
	logic [ST_W-1:0]         status_q;
	logic                    last_q;
	logic                    swapped_q;
	logic [DIV_W-1:0]        d_q;
	logic [2*DIV_W-1:0]      prod_q;

	logic [ST_W-1:0]         o_status_q;
	logic [CW-1:0]           o_count_q;
	logic [CW-1:0]           o_pos_q;
	logic signed [VAL_W-1:0] o_elem_q;
	logic signed [VAL_W-1:0] o_hi_q;
	logic [CW-1:0]           o_primes_q;
	logic [SQ_W-1:0]         o_sq_q;
	logic                    o_last_q;

	logic [IW-1:0]           front_dec;
	logic [IW-1:0]           front_inc;
	logic                    scan_end;
	logic                    cur_gt;
	logic                    wr_en;
	logic [IW-1:0]           wr_addr;
	logic signed [VAL_W-1:0] wr_data;
	logic [DIV_W-1:0]        divisor;
	logic                    math_done;
	logic                    math_zero;

	// Position of list entry off, counted from the front, in the ring.
	function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
	                                          input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	assign front_dec = (front_q == '0) ? IW'(DEPTH-1) : front_q - IW'(1);
	assign front_inc = (front_q == IW'(DEPTH-1)) ? '0 : front_q + IW'(1);
	assign scan_end  = (op_q == OP_SORT) ? (k_q == e_q) : (k_q == cnt_q - CW'(1));
	assign cur_gt    = cur_q > rd_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_of(front_q, cnt_q);
		wr_data = v_q;
		priority if (cmd.ins_head) begin
			wr_en   = 1'b1;
			wr_addr = front_dec;
		end else if (cmd.ins_tail) begin
			wr_en = 1'b1;
		end else if (cmd.ins_second) begin
			wr_en   = 1'b1;
			wr_data = v2_q;
		end else if (cmd.keep_wr) begin
			wr_en   = 1'b1;
			wr_addr = slot_of(front_q, w_q);
			wr_data = rd_q;
		end else if (cmd.sort_cmp) begin
			wr_en   = 1'b1;
			wr_addr = slot_of(front_q, k_q - CW'(1));
			wr_data = cur_gt ? rd_q : cur_q;
		end else if (cmd.sort_end) begin
			wr_en   = 1'b1;
			wr_addr = slot_of(front_q, e_q);
			wr_data = cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mem[slot_of(front_q, k_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_head) begin
				front_q <= front_dec;
				cnt_q   <= cnt_q + CW'(1);
			end
			if (cmd.ins_tail || cmd.ins_second) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.del_head) begin
				front_q <= front_inc;
				cnt_q   <= cnt_q - CW'(1);
			end
			if (cmd.del_tail) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.set_cnt_w) begin
				cnt_q <= cmd.keep_wr ? w_q + CW'(1) : w_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= opcode;
			v_q       <= value;
			v2_q      <= second_value;
			k_q       <= '0;
			w_q       <= '0;
			e_q       <= cnt_q - CW'(1);
			swapped_q <= 1'b0;
			status_q  <= ST_OK;
			pos_q     <= '0;
			elem_q    <= '0;
			hi_q      <= '0;
			primes_q  <= '0;
			sq_q      <= '0;
			last_q    <= 1'b1;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status_val;
		end
		if (cmd.step) begin
			k_q <= k_q + CW'(1);
		end
		if (cmd.keep_wr) begin
			w_q <= w_q + CW'(1);
		end
		if (cmd.sort_first) begin
			cur_q <= rd_q;
		end
		if (cmd.sort_cmp) begin
			if (cur_gt) begin
				swapped_q <= 1'b1;
			end else begin
				cur_q <= rd_q;
			end
		end
		if (cmd.sort_end) begin
			e_q       <= e_q - CW'(1);
			k_q       <= '0;
			swapped_q <= 1'b0;
		end
		if (cmd.mm_first) begin
			elem_q <= rd_q;
			hi_q   <= rd_q;
		end
		if (cmd.mm_upd) begin
			if (rd_q < elem_q) begin
				elem_q <= rd_q;
			end
			if (rd_q > hi_q) begin
				hi_q <= rd_q;
			end
		end
		if (cmd.found) begin
			pos_q <= k_q + CW'(1);
		end
		if (cmd.prime_inc) begin
			primes_q <= primes_q + CW'(1);
		end
		if (cmd.sq_add) begin
			sq_q <= sq_q + SQ_W'(rd_q[30:0]);
		end
		if (cmd.d_init) begin
			d_q <= DIV_W'(5);
		end
		if (cmd.d_step) begin
			d_q <= d_q + DIV_W'(6);
		end
		if (cmd.sq_load) begin
			prod_q <= d_q * d_q;
		end
		if (cmd.set_elem) begin
			elem_q <= rd_q;
			last_q <= scan_end;
		end
		if (cmd.emit) begin
			o_status_q <= status_q;
			o_count_q  <= cnt_q;
			o_pos_q    <= pos_q;
			o_elem_q   <= elem_q;
			o_hi_q     <= hi_q;
			o_primes_q <= primes_q;
			o_sq_q     <= sq_q;
			o_last_q   <= last_q;
		end
	end

	always_comb begin
		unique case (cmd.math_sel)
			MS_MOD3:  divisor = DIV_W'(3);
			MS_MODD:  divisor = d_q;
			MS_MODD2: divisor = d_q + DIV_W'(2);
			MS_SQRT:  divisor = d_q;
			default:  divisor = d_q;
		endcase
	end

	blce_math u_math (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.math_start),
		.is_sqrt (cmd.math_sel == MS_SQRT),
		.operand (rd_q[30:0]),
		.divisor (divisor),
		.done    (math_done),
		.zero    (math_zero)
	);

	always_comb begin
		stat.op        = op_q;
		stat.full      = cnt_q == CW'(DEPTH);
		stat.pair_full = cnt_q >= CW'(DEPTH-1);
		stat.empty     = cnt_q == '0;
		stat.scan_end  = scan_end;
		stat.k_zero    = k_q == '0;
		stat.eq        = rd_q == v_q;
		stat.gt        = rd_q > v_q;
		stat.t_lt2     = rd_q < 32'sd2;
		stat.t_lt4     = rd_q < 32'sd4;
		stat.t_even    = !rd_q[0];
		stat.t_neg     = rd_q[VAL_W-1];
		stat.math_done = math_done;
		stat.math_zero = math_zero;
		stat.prod_gt   = prod_q > (2*DIV_W)'(rd_q[30:0]);
		stat.swapped   = swapped_q;
		stat.e_le1     = e_q <= CW'(1);
		stat.last      = last_q;
		stat.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign status      = o_status_q;
	assign entry_count = o_count_q;
	assign position    = o_pos_q;
	assign element     = o_elem_q;
	assign largest     = o_hi_q;
	assign prime_count = o_primes_q;
	assign square_sum  = o_sq_q;
	assign last        = o_last_q;

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("Result loaded over a transaction still waiting.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("Entry count above the store depth.");

	a_tail_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins_tail || cmd.ins_second) |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("Tail insert did not grow the list by one.");

endmodule

[rtl/core/blce_ctrl.sv]
// ----------------------------------------------------------------------------
// blce_ctrl
// Controller: sequences each command over the datapath, one command at a
// time.
// ----------------------------------------------------------------------------
module blce_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  blce_pkg::dp_stat_t stat,
	output blce_pkg::dp_cmd_t  cmd
);
	import blce_pkg::*;

	state_t state_q;
	state_t state_d;
	state_t adv;
	logic   scan_op;

	assign scan_op = (stat.op == OP_SEARCH) ||
	                 (stat.op >= OP_DEL_GT && stat.op <= OP_READOUT);
	assign adv     = stat.scan_end ? S_EMIT : S_SCAN_RD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (stat.op == OP_INS_PAIR && !stat.pair_full) begin
					state_d = S_INS2;
				end else if (scan_op && !stat.empty) begin
					state_d = S_SCAN_RD;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_INS2:    state_d = S_EMIT;
			S_SCAN_RD: state_d = S_SCAN_CHK;
			S_SCAN_CHK: begin
				unique case (stat.op)
					OP_SEARCH:  state_d = (stat.eq || stat.scan_end) ? S_EMIT : S_SCAN_RD;
					OP_SORT:    state_d = stat.scan_end ? S_SORT_END : S_SCAN_RD;
					OP_PRIMES: begin
						if (!stat.t_lt2 && !stat.t_lt4 && !stat.t_even) state_d = S_PR_W3;
						else state_d = adv;
					end
					OP_SQUARES: state_d = stat.t_neg ? adv : S_SQ_W;
					OP_READOUT: state_d = S_EMIT;
					default:    state_d = adv;
				endcase
			end
			S_PR_W3: begin
				if (stat.math_done) state_d = stat.math_zero ? adv : S_PR_SQ;
			end
			S_PR_SQ:  state_d = S_PR_SQC;
			S_PR_SQC: state_d = stat.prod_gt ? adv : S_PR_WA;
			S_PR_WA: begin
				if (stat.math_done) state_d = stat.math_zero ? adv : S_PR_WB;
			end
			S_PR_WB: begin
				if (stat.math_done) state_d = stat.math_zero ? adv : S_PR_SQ;
			end
			S_SQ_W: begin
				if (stat.math_done) state_d = adv;
			end
			S_SORT_END: begin
				state_d = (!stat.swapped || stat.e_le1) ? S_EMIT : S_SCAN_RD;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					state_d = (stat.op == OP_READOUT && !stat.last) ? S_SCAN_RD : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.math_sel = MS_MOD3;
		unique case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_DECODE: begin
				unique case (stat.op)
					OP_INS_HEAD: begin
						cmd.set_status = stat.full;
						cmd.status_val = ST_FULL;
						cmd.ins_head   = !stat.full;
					end
					OP_INS_TAIL: begin
						cmd.set_status = stat.full;
						cmd.status_val = ST_FULL;
						cmd.ins_tail   = !stat.full;
					end
					OP_INS_PAIR: begin
						cmd.set_status = stat.pair_full;
						cmd.status_val = ST_FULL;
						cmd.ins_tail   = !stat.pair_full;
					end
					OP_DEL_HEAD: begin
						cmd.set_status = stat.empty;
						cmd.status_val = ST_EMPTY;
						cmd.del_head   = !stat.empty;
					end
					OP_DEL_TAIL: begin
						cmd.set_status = stat.empty;
						cmd.status_val = ST_EMPTY;
						cmd.del_tail   = !stat.empty;
					end
					default: begin
						cmd.set_status = stat.empty && scan_op;
						cmd.status_val = ST_EMPTY;
					end
				endcase
			end
			S_INS2:    cmd.ins_second = 1'b1;
			S_SCAN_RD: cmd.rd = 1'b1;
			S_SCAN_CHK: begin
				unique case (stat.op)
					OP_SEARCH: begin
						if (stat.eq) begin
							cmd.found = 1'b1;
						end else if (stat.scan_end) begin
							cmd.set_status = 1'b1;
							cmd.status_val = ST_MISS;
						end else begin
							cmd.step = 1'b1;
						end
					end
					OP_DEL_GT: begin
						cmd.keep_wr   = !stat.gt;
						cmd.set_cnt_w = stat.scan_end;
						cmd.step      = !stat.scan_end;
					end
					OP_DEL_EVEN: begin
						cmd.keep_wr   = !stat.t_even;
						cmd.set_cnt_w = stat.scan_end;
						cmd.step      = !stat.scan_end;
					end
					OP_SORT: begin
						cmd.sort_first = stat.k_zero;
						cmd.sort_cmp   = !stat.k_zero;
						cmd.step       = !stat.scan_end;
					end
					OP_PRIMES: begin
						if (stat.t_lt2 || stat.t_even) begin
							cmd.prime_inc = stat.t_lt4 && !stat.t_lt2;
							cmd.step      = !stat.scan_end;
						end else if (stat.t_lt4) begin
							cmd.prime_inc = 1'b1;
							cmd.step      = !stat.scan_end;
						end else begin
							cmd.math_start = 1'b1;
							cmd.math_sel   = MS_MOD3;
						end
					end
					OP_SQUARES: begin
						if (stat.t_neg) begin
							cmd.step = !stat.scan_end;
						end else begin
							cmd.math_start = 1'b1;
							cmd.math_sel   = MS_SQRT;
						end
					end
					OP_MINMAX: begin
						cmd.mm_first = stat.k_zero;
						cmd.mm_upd   = !stat.k_zero;
						cmd.step     = !stat.scan_end;
					end
					default: begin
						cmd.set_elem = 1'b1;
						cmd.step     = 1'b1;
					end
				endcase
			end
			S_PR_W3: begin
				if (stat.math_done) begin
					cmd.step   = stat.math_zero && !stat.scan_end;
					cmd.d_init = !stat.math_zero;
				end
			end
			S_PR_SQ: cmd.sq_load = 1'b1;
			S_PR_SQC: begin
				if (stat.prod_gt) begin
					cmd.prime_inc = 1'b1;
					cmd.step      = !stat.scan_end;
				end else begin
					cmd.math_start = 1'b1;
					cmd.math_sel   = MS_MODD;
				end
			end
			S_PR_WA: begin
				if (stat.math_done) begin
					cmd.step       = stat.math_zero && !stat.scan_end;
					cmd.math_start = !stat.math_zero;
					cmd.math_sel   = MS_MODD2;
				end
			end
			S_PR_WB: begin
				if (stat.math_done) begin
					cmd.step   = stat.math_zero && !stat.scan_end;
					cmd.d_step = !stat.math_zero;
				end
			end
			S_SQ_W: begin
				if (stat.math_done) begin
					cmd.sq_add = stat.math_zero;
					cmd.step   = !stat.scan_end;
				end
			end
			S_SORT_END: cmd.sort_end = 1'b1;
			S_EMIT:     cmd.emit = stat.out_free;
			default:    cmd.load = 1'b0;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

[rtl/core/bounded_list_command_engine.sv]
// ----------------------------------------------------------------------------
// bounded_list_command_engine
// Ordered list of up to DEPTH signed 32-bit entries, held as a ring in a
// single-port-write memory, that executes one list command per transaction.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   -------  ---------  -------------------  ------------------------------------
//   in       to block   in_valid / in_stall  opcode, value, second_value
//   out      from block out_valid/out_stall  status, entry_count, position,
//                                            element, largest, prime_count,
//                                            square_sum, last
//
// Commands that walk the list read each entry and then check it, since the
// memory read data is registered. Sort runs bubble passes and stops on a
// pass without swaps. The prime count is set by the remainder unit over
// trial divisors, and the square sum by the root unit. Readout gives one
// transaction per entry.
// Reset clears the list pointers and the output valid flag; the memory is not
// cleared, because only entries inside the stored count are ever read.
// The block takes one command at a time; it takes the next command while the
// final result of the previous one still waits under out_stall.
//
module bounded_list_command_engine #(
	parameter int DEPTH = blce_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [blce_pkg::OP_W-1:0]         opcode,
	input  logic signed [blce_pkg::VAL_W-1:0] value,
	input  logic signed [blce_pkg::VAL_W-1:0] second_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [blce_pkg::ST_W-1:0]         status,
	output logic [$clog2(DEPTH+1)-1:0]        entry_count,
	output logic [$clog2(DEPTH+1)-1:0]        position,
	output logic signed [blce_pkg::VAL_W-1:0] element,
	output logic signed [blce_pkg::VAL_W-1:0] largest,
	output logic [$clog2(DEPTH+1)-1:0]        prime_count,
	output logic [blce_pkg::SQ_W-1:0]         square_sum,
	output logic                              last
);
	import blce_pkg::*;

	// The controller decides the step of each command; the datapath reports
	// compare results, list bounds and the state of the arithmetic unit.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	blce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath latches the command fields when the transaction is taken
	// and holds the list memory, scan counters and output register.
	blce_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.opcode       (opcode),
		.value        (value),
		.second_value (second_value),
		.cmd          (cmd),
		.stat         (stat),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.entry_count  (entry_count),
		.position     (position),
		.element      (element),
		.largest      (largest),
		.prime_count  (prime_count),
		.square_sum   (square_sum),
		.last         (last)
	);

endmodule

[test/tb_bounded_list_command_engine.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_list_command_engine
// Self-checking bench for the list command engine: a directed opening, then
// random grow, shrink and mixed phases of commands, checked against a local
// model of the list that runs ahead as the commands are generated.
// ----------------------------------------------------------------------------
module tb_bounded_list_command_engine;
	import blce_pkg::*;

	localparam int LIST_DEPTH = 64;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int RANDOM_ITEMS = 180;
	localparam int CALM_TAIL = 30;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic signed [VAL_W-1:0] v;
		logic signed [VAL_W-1:0] v2;
	} command_t;

	typedef struct packed {
		logic [ST_W-1:0]         st;
		logic [CW-1:0]           cnt;
		logic [CW-1:0]           pos;
		logic signed [VAL_W-1:0] elem;
		logic signed [VAL_W-1:0] big;
		logic [CW-1:0]           pr;
		logic [SQ_W-1:0]         sq;
		logic                    lst;
	} result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [OP_W-1:0] opcode;
	logic signed [VAL_W-1:0] value;
	logic signed [VAL_W-1:0] second_value;
	logic out_valid;
	logic out_stall;
	logic [ST_W-1:0] status;
	logic [CW-1:0] entry_count;
	logic [CW-1:0] position;
	logic signed [VAL_W-1:0] element;
	logic signed [VAL_W-1:0] largest;
	logic [CW-1:0] prime_count;
	logic [SQ_W-1:0] square_sum;
	logic last;

	bounded_list_command_engine #(.DEPTH(LIST_DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .value(value), .second_value(second_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .entry_count(entry_count), .position(position),
		.element(element), .largest(largest), .prime_count(prime_count),
		.square_sum(square_sum), .last(last)
	);

	// Commands waiting for the driver, and the results the list must give back.
	command_t pending_cmds[$];
	result_t  expected_results[$];
	int mismatches = 0;
	int results_seen = 0;

	// Shadow copy of the list: a ring of entries, a front index and a count.
	logic signed [VAL_W-1:0] shadow_ring[LIST_DEPTH];
	logic [5:0] shadow_front = '0;
	int shadow_count = 0;

	function automatic logic [5:0] ring_at(input int k);
		return shadow_front + 6'(k);
	endfunction

	function automatic bit is_prime_value(input longint n);
		longint d;
		if (n < 2) return 0;
		if (n < 4) return 1;
		if (n % 2 == 0 || n % 3 == 0) return 0;
		for (d = 5; d * d <= n; d += 6)
			if (n % d == 0 || n % (d + 2) == 0) return 0;
		return 1;
	endfunction

	function automatic bit is_square_value(input longint n);
		longint lo, hi, mid;
		lo = 0;
		hi = 46341;
		if (n < 0) return 0;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= n) lo = mid;
			else hi = mid - 1;
		end
		return lo * lo == n;
	endfunction

	// Builds one result with status, count and last set; the other fields stay zero.
	function automatic result_t make_result(input logic [ST_W-1:0] st);
		result_t r;
		r = '0;
		r.st = st;
		r.cnt = CW'(shadow_count);
		r.lst = 1'b1;
		return r;
	endfunction

	// Applies one command to the shadow list and queues the results it yields.
	task automatic apply_list_command(input command_t c);
		result_t r;
		int k, w, need;
		logic signed [VAL_W-1:0] t, lo, hi;
		longint sq;
		int primes;
		r = '0;
		if (c.op == OP_INS_HEAD || c.op == OP_INS_TAIL || c.op == OP_INS_PAIR) begin
			need = (c.op == OP_INS_PAIR) ? 2 : 1;
			if (shadow_count + need > LIST_DEPTH) begin
				expected_results.push_back(make_result(ST_FULL));
				return;
			end
			if (c.op == OP_INS_HEAD) begin
				shadow_front = shadow_front - 6'd1;
				shadow_ring[shadow_front] = c.v;
			end else begin
				shadow_ring[ring_at(shadow_count)] = c.v;
				if (c.op == OP_INS_PAIR) shadow_ring[ring_at(shadow_count + 1)] = c.v2;
			end
			shadow_count += need;
			expected_results.push_back(make_result(ST_OK));
			return;
		end
		if (c.op > OP_READOUT) begin
			expected_results.push_back(make_result(ST_OK));
			return;
		end
		if (shadow_count == 0) begin
			expected_results.push_back(make_result(ST_EMPTY));
			return;
		end
		case (c.op)
			OP_SEARCH: begin
				r = make_result(ST_MISS);
				for (k = 0; k < shadow_count; k++)
					if (shadow_ring[ring_at(k)] == c.v) begin
						r.st = ST_OK;
						r.pos = CW'(k + 1);
						break;
					end
			end
			OP_DEL_HEAD: begin
				shadow_front = shadow_front + 6'd1;
				shadow_count--;
				r = make_result(ST_OK);
			end
			OP_DEL_TAIL: begin
				shadow_count--;
				r = make_result(ST_OK);
			end
			OP_DEL_GT, OP_DEL_EVEN: begin
				// Compact the survivors toward the front, keeping their order.
				w = 0;
				for (k = 0; k < shadow_count; k++) begin
					t = shadow_ring[ring_at(k)];
					if (!((c.op == OP_DEL_GT) ? (t > c.v) : (t[0] == 1'b0))) begin
						shadow_ring[ring_at(w)] = t;
						w++;
					end
				end
				shadow_count = w;
				r = make_result(ST_OK);
			end
			OP_SORT: begin
				for (k = 1; k < shadow_count; k++) begin
					t = shadow_ring[ring_at(k)];
					w = k;
					while (w > 0 && shadow_ring[ring_at(w - 1)] > t) begin
						shadow_ring[ring_at(w)] = shadow_ring[ring_at(w - 1)];
						w--;
					end
					shadow_ring[ring_at(w)] = t;
				end
				r = make_result(ST_OK);
			end
			OP_PRIMES: begin
				primes = 0;
				for (k = 0; k < shadow_count; k++)
					if (is_prime_value(longint'(shadow_ring[ring_at(k)]))) primes++;
				r = make_result(ST_OK);
				r.pr = CW'(primes);
			end
			OP_SQUARES: begin
				sq = 0;
				for (k = 0; k < shadow_count; k++) begin
					t = shadow_ring[ring_at(k)];
					if (is_square_value(longint'(t))) sq += longint'(t);
				end
				r = make_result(ST_OK);
				r.sq = SQ_W'(sq);
			end
			OP_MINMAX: begin
				lo = shadow_ring[ring_at(0)];
				hi = lo;
				for (k = 1; k < shadow_count; k++) begin
					t = shadow_ring[ring_at(k)];
					if (t < lo) lo = t;
					if (t > hi) hi = t;
				end
				r = make_result(ST_OK);
				r.elem = lo;
				r.big = hi;
			end
			default: begin
				// Readout gives one transaction per entry, the final one marked last.
				for (k = 0; k < shadow_count; k++) begin
					r = make_result(ST_OK);
					r.elem = shadow_ring[ring_at(k)];
					r.lst = (k + 1 == shadow_count);
					expected_results.push_back(r);
				end
				return;
			end
		endcase
		expected_results.push_back(r);
	endtask

	task automatic issue(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] v,
			input logic signed [VAL_W-1:0] v2);
		command_t c;
		c.op = op;
		c.v = v;
		c.v2 = v2;
		pending_cmds.push_back(c);
		apply_list_command(c);
	endtask

	// Random value: half the time small so that primes and sort stay short, sometimes
	// the full range, sometimes a square or a value already in the list.
	function automatic logic signed [VAL_W-1:0] pick_value();
		int sel;
		int root;
		sel = $urandom_range(0, 9);
		if (sel <= 4) return int'($urandom_range(0, 300)) - 100;
		if (sel == 5 || sel == 6) return $urandom;
		if (sel == 7 && shadow_count > 0)
			return shadow_ring[ring_at($urandom_range(0, shadow_count - 1))];
		root = $urandom_range(0, 300);
		return root * root;
	endfunction

	// Trial division of a large entry is very slow in the block, so the random
	// phases ask for a prime count only while every positive entry is modest.
	function automatic bit list_has_large_entry();
		for (int k = 0; k < shadow_count; k++)
			if (shadow_ring[ring_at(k)] > 1000000) return 1;
		return 0;
	endfunction

	task automatic build_stimulus();
		int n, mode, seg_left, roll;
		logic [OP_W-1:0] op;
		// Directed opening: empty list, extremes, every command, unused codes.
		issue(OP_READOUT, 0, 0);
		issue(OP_DEL_HEAD, 0, 0);
		issue(OP_SEARCH, 5, 0);
		issue(OP_INS_TAIL, 32'sh7fffffff, 0);
		issue(OP_INS_HEAD, 32'sh80000000, 0);
		issue(OP_INS_PAIR, 0, 46340 * 46340);
		issue(OP_INS_TAIL, -4, 32'sh7fffffff);
		issue(OP_SEARCH, -4, 0);
		issue(OP_SEARCH, 7, 0);
		issue(OP_MINMAX, 0, 0);
		issue(OP_SQUARES, 0, 0);
		issue(OP_SORT, 0, 0);
		issue(OP_READOUT, 0, 0);
		issue(OP_DEL_GT, 1000, 0);
		issue(OP_INS_TAIL, 1000003, 0);
		issue(OP_INS_TAIL, 2, 0);
		issue(OP_INS_PAIR, 9, 3);
		issue(OP_PRIMES, 0, 0);
		issue(OP_DEL_EVEN, 0, 0);
		issue(OP_READOUT, 0, 0);
		issue(OP_DEL_HEAD, 0, 0);
		issue(OP_DEL_TAIL, 0, 0);
		issue(4'd13, 1, 2);
		issue(4'd14, 32'sh7fffffff, 32'sh80000000);
		issue(4'd15, -1, -1);
		// Random phases. The first one mostly inserts, to grow the list.
		mode = 0;
		seg_left = 75;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (seg_left == 0) begin
				mode = $urandom_range(0, 2);
				seg_left = $urandom_range(10, 30);
			end
			seg_left--;
			roll = $urandom_range(0, 99);
			if ((mode == 0 && roll < 85) || (mode == 2 && roll < 35) || (mode == 1 && roll < 10))
				op = 4'($urandom_range(OP_INS_HEAD, OP_INS_PAIR));
			else if ((mode == 1 && roll < 70) || (mode == 2 && roll < 55))
				op = 4'($urandom_range(OP_DEL_HEAD, OP_DEL_EVEN));
			else
				op = 4'($urandom_range(OP_SEARCH, 15));
			if (op == OP_PRIMES && list_has_large_entry()) op = OP_MINMAX;
			issue(op, pick_value(), pick_value());
		end
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Near the end of the run the bench adds no new random gaps or stalls, so
	// the last transactions are not held up by the bench.
	wire calm = pending_cmds.size() < CALM_TAIL;

	// Driver: presents a command at the falling edge and holds it until the
	// block has taken it. Random gaps fall between transactions.
	logic in_taken;
	int send_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_cmds.size() == 0) begin
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(1, 14) - 1;
				in_valid <= 1'b0;
			end else begin
				opcode <= pending_cmds[0].op;
				value <= pending_cmds[0].v;
				second_value <= pending_cmds[0].v2;
				in_valid <= 1'b1;
				void'(pending_cmds.pop_front());
			end
		end
	end

	// Receiver stall: short random bursts, plus one long hold-off once enough
	// results have come, so that the block backs up into its input.
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && results_seen >= 40) begin
				hold_done = 1;
				hold_left = 300;
				out_stall <= 1'b1;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: every accepted result is checked against the oldest expectation.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {status, entry_count, position, element, largest, prime_count,
				square_sum, last};
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status=%0d count=%0d elem=%0d last=%0b",
						status, entry_count, element, last);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch on result %0d:", results_seen);
						$display("  expected st=%0d cnt=%0d pos=%0d elem=%0d big=%0d pr=%0d sq=%0d last=%0b",
							want.st, want.cnt, want.pos, want.elem, want.big, want.pr,
							want.sq, want.lst);
						$display("  actual   st=%0d cnt=%0d pos=%0d elem=%0d big=%0d pr=%0d sq=%0d last=%0b",
							got.st, got.cnt, got.pos, got.elem, got.big, got.pr,
							got.sq, got.lst);
					end
				end
			end
		end
	end

	// Main sequence: reset, build the stimulus, wait for the results to drain.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		opcode = '0;
		value = '0;
		second_value = '0;
		build_stimulus();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		while (pending_cmds.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		// Let any straggling transaction show up before the verdict.
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
